// ===== src/ssb_pkg.sv =====
// Shared definitions for the seven-segment command bridge: display codes,
// job kinds and the job record passed from the command parser to the run generator.
// No dependencies.
package ssb_pkg;

  localparam logic [7:0] CODE_CURSOR  = 8'h79;
  localparam logic [7:0] CODE_BRIGHT  = 8'h7A;
  localparam logic [7:0] CODE_DECIMAL = 8'h77;
  localparam logic [7:0] CODE_BLANK   = 8'h10;

  localparam logic DISP_RPM = 1'b0;
  localparam logic DISP_MPH = 1'b1;

  localparam logic [1:0] JOB_BRIGHT = 2'd0;
  localparam logic [1:0] JOB_CLEAR  = 2'd1;
  localparam logic [1:0] JOB_DEC    = 2'd2;
  localparam logic [1:0] JOB_VALUE  = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        disp;
    logic [7:0]  arg;
    logic [15:0] value;
  } ssb_job_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } ssb_qstat_t;

endpackage

// ===== src/ssb_ifs.sv =====
// Valid/ready channel interfaces for the received byte stream and the
// display byte stream. No dependencies.
interface ssb_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ssb_tx_if;
  logic       valid;
  logic       ready;
  logic       target_display;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, output target_display, output tx_byte, output last,
                  input ready);
  modport sink   (input valid, input target_display, input tx_byte, input last,
                  output ready);
endinterface

// ===== src/seven_segment_command_bridge.sv =====
// Seven-segment command bridge. Each accepted byte advances the parser; a job
// passes through the job queue to the run generator. Brightness, decimal and clear runs
// send 2 or 8 bytes at one per cycle while the output is ready; a value run first passes
// through the shift-and-add converter, then sends 8 to 14 bytes.
// The parser stalls only when the two-entry job queue is full.
// Synchronous active-low reset: parser idle, rpm value 0, mph value 2000, queue empty.
module seven_segment_command_bridge (
  input  logic     clk,
  input  logic     rst_n,
  ssb_rx_if.sink   in_ch,
  ssb_tx_if.source out_ch
);

  // Jobs flow from the parser through the queue into the run generator.
  ssb_pkg::ssb_job_t   push_job;
  ssb_pkg::ssb_job_t   head_job;
  ssb_pkg::ssb_qstat_t qstat;
  logic                push;
  logic                pop;

  // The front end parses command bytes and keeps the loaded values.
  ssb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .rx    (in_ch),
    .qstat (qstat),
    .push  (push),
    .job   (push_job)
  );

  // The queue lets the parser keep taking bytes while a run is being sent.
  ssb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .qstat    (qstat)
  );

  // The back end converts values and sends each run one beat per cycle while the output is ready.
  ssb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_job),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .tx         (out_ch)
  );

  // A full queue must hold off the input, otherwise a job would be lost.
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !in_ch.ready)
    else $error("input accepted while the job queue is full");

  // The queue never claims more entries than it holds.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= 2'(ssb_pkg::QUEUE_DEPTH))
    else $error("job queue count out of range");

  // After the final beat of a run the generator returns to idle before any further beat.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
    else $error("output beat directly after the end of a run");

  // A job can only be taken from a queue that holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("job taken from an empty queue");

endmodule

// ===== src/ssb_front.sv =====
// Command parser: takes received bytes, tracks the parser position and the
// loaded values, and pushes display jobs. Depends on ssb_pkg and ssb_rx_if.
module ssb_front (
  input  logic                clk,
  input  logic                rst_n,
  ssb_rx_if.sink              rx,
  input  ssb_pkg::ssb_qstat_t qstat,
  output logic                push,
  output ssb_pkg::ssb_job_t   job
);

  localparam logic [7:0] CMD_RPM     = 8'hFF;
  localparam logic [7:0] CMD_MPH     = 8'hFE;
  localparam logic [7:0] CMD_RPM_BR  = 8'hFD;
  localparam logic [7:0] CMD_MPH_BR  = 8'hFC;
  localparam logic [7:0] CMD_RPM_CL  = 8'hFB;
  localparam logic [7:0] CMD_MPH_CL  = 8'hFA;
  localparam logic [7:0] CMD_PATTERN = 8'hF9;
  localparam logic [7:0] CMD_DEC     = 8'hF7;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RPM_LO = 4'd1;
  localparam logic [3:0] ST_RPM_HI = 4'd2;
  localparam logic [3:0] ST_MPH_LO = 4'd3;
  localparam logic [3:0] ST_MPH_HI = 4'd4;
  localparam logic [3:0] ST_RPM_BR = 4'd5;
  localparam logic [3:0] ST_MPH_BR = 4'd6;
  localparam logic [3:0] ST_RPM_CL = 4'd7;
  localparam logic [3:0] ST_MPH_CL = 4'd8;
  localparam logic [3:0] ST_PAT1   = 4'd9;
  localparam logic [3:0] ST_PAT2   = 4'd10;
  localparam logic [3:0] ST_DEC1   = 4'd11;
  localparam logic [3:0] ST_DEC2   = 4'd12;
  localparam logic [3:0] ST_RPM_GO = 4'd13;
  localparam logic [3:0] ST_MPH_GO = 4'd14;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] rpm_r, rpm_nxt;
  logic [15:0] mph_r, mph_nxt;
  logic        accept;

  // Decimal point place to display parameter; out-of-range places switch it off.
  function automatic logic [7:0] dec_param(input logic [7:0] d);
    logic [7:0] p;
    case (d)
      8'd1:    p = 8'd1;
      8'd2:    p = 8'd2;
      8'd3:    p = 8'd4;
      8'd4:    p = 8'd8;
      default: p = 8'd0;
    endcase
    return p;
  endfunction

  assign rx.ready = !qstat.full;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    state_nxt = state_r;
    rpm_nxt   = rpm_r;
    mph_nxt   = mph_r;
    push      = 1'b0;
    job       = '{kind: ssb_pkg::JOB_BRIGHT, disp: ssb_pkg::DISP_RPM,
                  arg: rx.rx_byte, value: rpm_r};
    if (accept) begin
      state_nxt = ST_IDLE;
      case (state_r)
        ST_IDLE: begin
          case (rx.rx_byte)
            CMD_RPM: begin
              state_nxt = ST_RPM_LO;
              rpm_nxt   = 16'd0;
            end
            CMD_MPH: begin
              state_nxt = ST_MPH_LO;
              mph_nxt   = 16'd0;
            end
            CMD_RPM_BR:  state_nxt = ST_RPM_BR;
            CMD_MPH_BR:  state_nxt = ST_MPH_BR;
            CMD_RPM_CL:  state_nxt = ST_RPM_CL;
            CMD_MPH_CL:  state_nxt = ST_MPH_CL;
            CMD_DEC:     state_nxt = ST_DEC1;
            CMD_PATTERN: state_nxt = ST_PAT1;
            default:     state_nxt = ST_IDLE;
          endcase
        end
        ST_RPM_LO: begin
          rpm_nxt   = {8'h00, rx.rx_byte};
          state_nxt = ST_RPM_HI;
        end
        ST_RPM_HI: begin
          rpm_nxt   = rpm_r | {rx.rx_byte, 8'h00};
          state_nxt = ST_RPM_GO;
        end
        ST_MPH_LO: begin
          mph_nxt   = {8'h00, rx.rx_byte};
          state_nxt = ST_MPH_HI;
        end
        ST_MPH_HI: begin
          mph_nxt   = mph_r | {rx.rx_byte, 8'h00};
          state_nxt = ST_MPH_GO;
        end
        ST_RPM_BR: begin
          push     = 1'b1;
          job.kind = ssb_pkg::JOB_BRIGHT;
          job.disp = ssb_pkg::DISP_RPM;
        end
        ST_MPH_BR: begin
          push     = 1'b1;
          job.kind = ssb_pkg::JOB_BRIGHT;
          job.disp = ssb_pkg::DISP_MPH;
        end
        ST_RPM_CL: begin
          push     = 1'b1;
          job.kind = ssb_pkg::JOB_CLEAR;
          job.disp = ssb_pkg::DISP_RPM;
        end
        ST_MPH_CL: begin
          push     = 1'b1;
          job.kind = ssb_pkg::JOB_CLEAR;
          job.disp = ssb_pkg::DISP_MPH;
        end
        ST_PAT1: state_nxt = ST_PAT2;
        ST_PAT2: state_nxt = ST_IDLE;
        ST_DEC1: state_nxt = ST_DEC2;
        ST_DEC2: begin
          push     = 1'b1;
          job.kind = ssb_pkg::JOB_DEC;
          job.disp = ssb_pkg::DISP_MPH;
          job.arg  = dec_param(rx.rx_byte);
        end
        ST_RPM_GO: begin
          push      = 1'b1;
          job.kind  = ssb_pkg::JOB_VALUE;
          job.disp  = ssb_pkg::DISP_RPM;
          job.value = rpm_r;
        end
        ST_MPH_GO: begin
          push      = 1'b1;
          job.kind  = ssb_pkg::JOB_VALUE;
          job.disp  = ssb_pkg::DISP_MPH;
          job.value = mph_r;
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rpm_r   <= 16'd0;
      mph_r   <= 16'd2000;
    end else begin
      state_r <= state_nxt;
      rpm_r   <= rpm_nxt;
      mph_r   <= mph_nxt;
    end
  end

endmodule

// ===== src/ssb_queue.sv =====
// Two-entry job queue between the command parser and the run generator.
// Depends on ssb_pkg.
module ssb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ssb_pkg::ssb_job_t   push_job,
  input  logic                pop,
  output ssb_pkg::ssb_job_t   head,
  output ssb_pkg::ssb_qstat_t qstat
);

  ssb_pkg::ssb_job_t mem_r [ssb_pkg::QUEUE_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign qstat.count = cnt_r;
  assign qstat.full  = (cnt_r == 2'(ssb_pkg::QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == 2'd0);
  assign head        = mem_r[rp_r];

  assign do_push = push && !qstat.full;
  assign do_pop  = pop && !qstat.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

endmodule

// ===== src/ssb_back.sv =====
// Run generator: takes one job at a time, converts values to decimal digits
// by shift-and-add-three, then sends the byte run. Depends on ssb_pkg and ssb_tx_if.
module ssb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ssb_pkg::ssb_job_t head,
  input  logic              head_valid,
  output logic              pop,
  ssb_tx_if.source          tx
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_CONV = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        disp_r, disp_nxt;
  logic [7:0]  arg_r, arg_nxt;
  logic [15:0] val_r, val_nxt;
  logic [15:0] bcd_r, bcd_nxt;
  logic [1:0]  top_r, top_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  logic [15:0] bcd_adj;
  logic [1:0]  nb;
  logic [3:0]  blank_end, digit_end, run_len, off, dofs;
  logic [1:0]  pos, kblk;
  logic [7:0]  byte_out;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                     : bcd_r[i*4 +: 4];
    end
  end

  // Value run layout: two cursor bytes, three bytes per blanked position,
  // the significant digits, then two cursor bytes again.
  assign nb        = 2'd3 - top_r;
  assign blank_end = 4'd2 + {2'b00, nb} + {1'b0, nb, 1'b0};
  assign digit_end = blank_end + {2'b00, top_r} + 4'd1;
  assign off       = cnt_r - 4'd2;
  assign dofs      = cnt_r - blank_end;
  assign pos       = top_r - dofs[1:0];

  always_comb begin
    if (off < 4'd3) begin
      kblk = 2'd1;
    end else if (off < 4'd6) begin
      kblk = 2'd2;
    end else begin
      kblk = 2'd3;
    end
  end

  always_comb begin
    byte_out = 8'h00;
    run_len  = 4'd2;
    case (kind_r)
      ssb_pkg::JOB_BRIGHT: begin
        byte_out = (cnt_r == 4'd0) ? ssb_pkg::CODE_BRIGHT : arg_r;
      end
      ssb_pkg::JOB_DEC: begin
        byte_out = (cnt_r == 4'd0) ? ssb_pkg::CODE_DECIMAL : arg_r;
      end
      ssb_pkg::JOB_CLEAR: begin
        run_len = 4'd8;
        case (cnt_r)
          4'd0, 4'd6:             byte_out = ssb_pkg::CODE_CURSOR;
          4'd2, 4'd3, 4'd4, 4'd5: byte_out = ssb_pkg::CODE_BLANK;
          default:                byte_out = 8'h00;
        endcase
      end
      ssb_pkg::JOB_VALUE: begin
        run_len = 4'd14 - {1'b0, top_r, 1'b0};
        if (cnt_r < 4'd2) begin
          byte_out = (cnt_r == 4'd0) ? ssb_pkg::CODE_CURSOR : 8'h00;
        end else if (cnt_r < blank_end) begin
          case (off - ({2'b00, kblk} - 4'd1) * 4'd3)
            4'd0:    byte_out = ssb_pkg::CODE_BLANK;
            4'd1:    byte_out = ssb_pkg::CODE_CURSOR;
            default: byte_out = {6'd0, kblk};
          endcase
        end else if (cnt_r < digit_end) begin
          byte_out = {4'd0, bcd_r[{pos, 2'b00} +: 4]};
        end else begin
          byte_out = (cnt_r == digit_end) ? ssb_pkg::CODE_CURSOR : 8'h00;
        end
      end
      default: byte_out = 8'h00;
    endcase
  end

  assign tx.valid          = (state_r == B_EMIT);
  assign tx.target_display = disp_r;
  assign tx.tx_byte        = byte_out;
  assign tx.last           = (cnt_r == run_len - 4'd1);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    disp_nxt  = disp_r;
    arg_nxt   = arg_r;
    val_nxt   = val_r;
    bcd_nxt   = bcd_r;
    top_nxt   = top_r;
    cnt_nxt   = cnt_r;
    pop       = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (head_valid) begin
          pop      = 1'b1;
          kind_nxt = head.kind;
          disp_nxt = head.disp;
          arg_nxt  = head.arg;
          val_nxt  = head.value;
          bcd_nxt  = 16'd0;
          cnt_nxt  = 4'd0;
          if (head.value >= 16'd1000) begin
            top_nxt = 2'd3;
          end else if (head.value >= 16'd100) begin
            top_nxt = 2'd2;
          end else if (head.value >= 16'd10) begin
            top_nxt = 2'd1;
          end else begin
            top_nxt = 2'd0;
          end
          state_nxt = (head.kind == ssb_pkg::JOB_VALUE) ? B_CONV : B_EMIT;
        end
      end
      B_CONV: begin
        bcd_nxt = {bcd_adj[14:0], val_r[15]};
        val_nxt = {val_r[14:0], 1'b0};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (tx.ready) begin
          if (tx.last) begin
            state_nxt = B_IDLE;
            cnt_nxt   = 4'd0;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    disp_r <= disp_nxt;
    arg_r  <= arg_nxt;
    val_r  <= val_nxt;
    bcd_r  <= bcd_nxt;
    top_r  <= top_nxt;
  end

endmodule
